// File: sv/lpd_pkg.sv
// Shared constants and types for the length-prefixed deframer.
`timescale 1ns / 1ps

package lpd_pkg;

    // Bytes in each string length header, little-endian.
    localparam int LENGTH_FIELD_BYTES = 4;
    // Message byte counter holds COUNT_BITS+1 bits and saturates.
    localparam int COUNT_BITS = 16;

    localparam int DATA_W    = 8;
    localparam int CFG_W     = 16;
    localparam int APB_DW    = 32;
    localparam int APB_AW    = 3;
    localparam int HDR_CNT_W = 2;
    localparam int ACC_W     = 8 * LENGTH_FIELD_BYTES;
    localparam int LEN_CMP_W = (ACC_W > CFG_W) ? ACC_W : CFG_W;
    localparam int MSG_CNT_W = COUNT_BITS + 1;
    localparam int MSG_CMP_W = (MSG_CNT_W > CFG_W) ? MSG_CNT_W : CFG_W;
    localparam int REM_W     = 16;

    localparam logic [CFG_W-1:0] MAX_STRING_RESET  = 16'd4096;
    localparam logic [CFG_W-1:0] MAX_MESSAGE_RESET = 16'd16384;

    // Register index, taken from paddr[2].
    typedef enum logic {
        REG_MAX_STRING  = 1'b0,
        REG_MAX_MESSAGE = 1'b1
    } reg_index_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_MSG_LONG = 2'd1,
        ST_STR_LONG = 2'd2,
        ST_TRUNC    = 2'd3
    } status_t;

endpackage

// File: sv/length_prefix_deframer.sv
// Length-prefixed string deframer: byte parser, config registers and result register.
`timescale 1ns / 1ps

// Takes one message byte per transfer and accepts a new byte in each unstalled cycle:
// each accepted byte updates the header/body parse state in the cycle it arrives, and
// any result it causes (a string byte, a string end, or the message end with its
// status) is loaded into a single result register. in_stall rises only while that
// register holds a result and the downstream side stalls; without such stalls the
// rate is one byte per cycle. Headers are LENGTH_FIELD_BYTES little-endian bytes; an
// empty string yields a string_end with no byte. Status is reported on the
// message_end result only: message too long, then string too long, then truncated.
// After a string too long the rest of the message is dropped. Configuration registers
// sit at byte addresses 0 (max_string_length) and 4 (max_message_length).
module length_prefix_deframer
    import lpd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,

    input  logic              in_valid,
    output logic              in_stall,
    input  logic [DATA_W-1:0] data_byte,
    input  logic              message_last,

    output logic              out_valid,
    input  logic              out_stall,
    output logic              byte_valid,
    output logic [DATA_W-1:0] out_byte,
    output logic              string_end,
    output logic              message_end,
    output logic [1:0]        status,

    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    logic [CFG_W-1:0]     max_str_reg;
    logic [CFG_W-1:0]     max_msg_reg;

    logic                 in_header_reg,  in_header_next;
    logic [HDR_CNT_W-1:0] hdr_cnt_reg,    hdr_cnt_next;
    logic [ACC_W-1:0]     len_acc_reg,    len_acc_next;
    logic [REM_W-1:0]     remain_reg,     remain_next;
    logic [MSG_CNT_W-1:0] msg_cnt_reg,    msg_cnt_next;
    status_t              err_reg,        err_next;

    logic                 out_valid_reg;
    logic                 byte_valid_reg;
    logic [DATA_W-1:0]    out_byte_reg;
    logic                 string_end_reg;
    logic                 message_end_reg;
    status_t              status_reg;

    logic                 in_fire;
    logic                 emit;
    logic                 bvalid;
    logic                 send;
    status_t              status_next;
    logic [ACC_W-1:0]     hdr_len;
    logic [LEN_CMP_W-1:0] hdr_len_ext;
    logic                 cfg_write;
    reg_index_t           cfg_index;

    // ---------------- configuration port ----------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_index = reg_index_t'(paddr[2]);

    always_comb
    begin
        case (cfg_index)
            REG_MAX_STRING:  prdata = APB_DW'(max_str_reg);
            REG_MAX_MESSAGE: prdata = APB_DW'(max_msg_reg);
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_str_reg <= MAX_STRING_RESET;
            max_msg_reg <= MAX_MESSAGE_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_MAX_STRING:  max_str_reg <= pwdata[CFG_W-1:0];
                REG_MAX_MESSAGE: max_msg_reg <= pwdata[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- parser ----------------
    assign in_stall = out_valid_reg && out_stall;
    assign in_fire  = in_valid && !in_stall;

    assign hdr_len     = len_acc_reg | (ACC_W'(data_byte) << {hdr_cnt_reg, 3'b000});
    assign hdr_len_ext = LEN_CMP_W'(hdr_len);

    always_comb
    begin
        in_header_next = in_header_reg;
        hdr_cnt_next   = hdr_cnt_reg;
        len_acc_next   = len_acc_reg;
        remain_next    = remain_reg;
        err_next       = err_reg;
        bvalid         = 1'b0;
        send           = 1'b0;
        status_next    = ST_OK;

        msg_cnt_next = msg_cnt_reg;
        if (msg_cnt_reg != {MSG_CNT_W{1'b1}})
            msg_cnt_next = msg_cnt_reg + MSG_CNT_W'(1);

        if (err_reg == ST_OK)
        begin
            if (in_header_reg)
            begin
                if ((3'(hdr_cnt_reg) + 3'd1) >= 3'(LENGTH_FIELD_BYTES))
                begin
                    hdr_cnt_next = '0;
                    len_acc_next = '0;
                    if (hdr_len_ext > LEN_CMP_W'(max_str_reg))
                        err_next = ST_STR_LONG;
                    else if (hdr_len == '0)
                        send = 1'b1;
                    else
                    begin
                        remain_next    = hdr_len_ext[REM_W-1:0];
                        in_header_next = 1'b0;
                    end
                end
                else
                begin
                    hdr_cnt_next = hdr_cnt_reg + HDR_CNT_W'(1);
                    len_acc_next = hdr_len;
                end
            end
            else
            begin
                bvalid      = 1'b1;
                remain_next = remain_reg - REM_W'(1);
                if (remain_next == '0)
                begin
                    send           = 1'b1;
                    in_header_next = 1'b1;
                end
            end
        end

        if (message_last)
        begin
            if (MSG_CMP_W'(msg_cnt_next) > MSG_CMP_W'(max_msg_reg))
                status_next = ST_MSG_LONG;
            else if (err_next == ST_STR_LONG)
                status_next = ST_STR_LONG;
            else if (!in_header_next || hdr_cnt_next != '0)
                status_next = ST_TRUNC;
            else
                status_next = ST_OK;
            // start clean for the next message
            in_header_next = 1'b1;
            hdr_cnt_next   = '0;
            len_acc_next   = '0;
            remain_next    = '0;
            msg_cnt_next   = '0;
            err_next       = ST_OK;
        end
    end

    assign emit = bvalid || send || message_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_header_reg <= 1'b1;
            hdr_cnt_reg   <= '0;
            len_acc_reg   <= '0;
            remain_reg    <= '0;
            msg_cnt_reg   <= '0;
            err_reg       <= ST_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                in_header_reg <= in_header_next;
                hdr_cnt_reg   <= hdr_cnt_next;
                len_acc_reg   <= len_acc_next;
                remain_reg    <= remain_next;
                msg_cnt_reg   <= msg_cnt_next;
                err_reg       <= err_next;
            end
            if (in_fire && emit)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // result payload: load only when a transfer produces a result
    always_ff @(posedge clk)
    begin
        if (in_fire && emit)
        begin
            byte_valid_reg  <= bvalid;
            out_byte_reg    <= bvalid ? data_byte : '0;
            string_end_reg  <= send;
            message_end_reg <= message_last;
            status_reg      <= status_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign byte_valid  = byte_valid_reg;
    assign out_byte    = out_byte_reg;
    assign string_end  = string_end_reg;
    assign message_end = message_end_reg;
    assign status      = status_reg;

    // ---------------- assertions ----------------
    a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("in_stall high with no pending result");

    a_status_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !message_end) |-> (status == ST_OK))
        else $error("nonzero status before message end");

    a_result_has_content: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (byte_valid || string_end || message_end))
        else $error("empty result emitted");

    a_byte_zero_if_invalid: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !byte_valid) |-> (out_byte == '0))
        else $error("out_byte nonzero without byte_valid");

    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && message_last) |=>
            (in_header_reg && hdr_cnt_reg == '0 && msg_cnt_reg == '0 && err_reg == ST_OK))
        else $error("parse state not cleared after message end");

endmodule
